>>> sv/dda_pkg.sv
// Shared command and status types for the DDA line rasterizer.
`default_nettype none
package dda_pkg;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // capture the endpoints of a new line
		logic setup;    // form deltas, step count and initial remainders
		logic advance;  // step to the next pixel
	} dda_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic last;     // current pixel is the final one of the line
	} dda_sts_t;

endpackage
`default_nettype wire

>>> sv/dda_ctrl.sv
// Controller state machine of the DDA line rasterizer.
`default_nettype none
module dda_ctrl
	import dda_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	output dda_cmd_t      cmd,
	input  wire dda_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign s_tready = in_ready_q;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd.load    = (state_q == ST_IDLE) && s_tvalid;
		cmd.setup   = (state_q == ST_SETUP);
		cmd.advance = (state_q == ST_EMIT) && m_tready && !sts.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q    <= ST_SETUP;
						in_ready_q <= 1'b0;
					end
				end
				ST_SETUP: begin
					state_q     <= ST_EMIT;
					out_valid_q <= 1'b1;
				end
				ST_EMIT: begin
					// drop valid after the final pixel transfer
					if (m_tready && sts.last) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					in_ready_q  <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/dda_datapath.sv
// Datapath of the DDA line rasterizer: endpoint capture, setup and stepping.
`default_nettype none
module dda_datapath
	import dda_pkg::*;
#(
	parameter int COORD_BITS = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dda_cmd_t              cmd,
	output dda_sts_t                   sts,
	input  wire logic [COORD_BITS-1:0] start_x,
	input  wire logic [COORD_BITS-1:0] start_y,
	input  wire logic [COORD_BITS-1:0] end_x,
	input  wire logic [COORD_BITS-1:0] end_y,
	output logic      [COORD_BITS-1:0] pixel_x,
	output logic      [COORD_BITS-1:0] pixel_y
);

	localparam int C  = COORD_BITS;
	localparam int SW = C + 3;

	logic        [C-1:0] sx_q, sy_q, ex_q, ey_q;
	logic        [C-1:0] px_q, py_q;
	logic signed [C+1:0] dx2_q, dy2_q;   // twice the signed deltas
	logic        [C:0]   den_q;          // twice the step count
	logic        [C:0]   rx_q, ry_q;     // remainders, 0 <= r < den when den > 0
	logic        [C-1:0] steps_q;
	logic        [C-1:0] cnt_q;

	// setup arithmetic
	logic signed [C:0]   dx, dy;
	logic        [C:0]   ax_w, ay_w;
	logic        [C-1:0] ax, ay, steps;

	always_comb begin
		dx    = $signed({1'b0, ex_q}) - $signed({1'b0, sx_q});
		dy    = $signed({1'b0, ey_q}) - $signed({1'b0, sy_q});
		ax_w  = dx[C] ? (C+1)'(-dx) : dx;
		ay_w  = dy[C] ? (C+1)'(-dy) : dy;
		ax    = ax_w[C-1:0];
		ay    = ay_w[C-1:0];
		steps = (ax > ay) ? ax : ay;
	end

	// step arithmetic: add 2d to the remainder, correct by one den at most
	logic signed [SW-1:0] den_ext, sum_x, sum_y;
	logic signed [SW-1:0] sub_x, sub_y, add_x, add_y;
	logic        [C:0]    rx_n, ry_n;
	logic        [C-1:0]  px_n, py_n;

	always_comb begin
		den_ext = $signed({2'b00, den_q});
		sum_x   = $signed({2'b00, rx_q}) + $signed({dx2_q[C+1], dx2_q});
		sum_y   = $signed({2'b00, ry_q}) + $signed({dy2_q[C+1], dy2_q});
		sub_x   = sum_x - den_ext;
		sub_y   = sum_y - den_ext;
		add_x   = sum_x + den_ext;
		add_y   = sum_y + den_ext;
		if (sum_x >= den_ext) begin
			rx_n = sub_x[C:0];
			px_n = px_q + 1'b1;
		end else if (sum_x < 0) begin
			rx_n = add_x[C:0];
			px_n = px_q - 1'b1;
		end else begin
			rx_n = sum_x[C:0];
			px_n = px_q;
		end
		if (sum_y >= den_ext) begin
			ry_n = sub_y[C:0];
			py_n = py_q + 1'b1;
		end else if (sum_y < 0) begin
			ry_n = add_y[C:0];
			py_n = py_q - 1'b1;
		end else begin
			ry_n = sum_y[C:0];
			py_n = py_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q <= start_x;
			sy_q <= start_y;
			ex_q <= end_x;
			ey_q <= end_y;
		end
		if (cmd.setup) begin
			px_q    <= sx_q;
			py_q    <= sy_q;
			dx2_q   <= {dx, 1'b0};
			dy2_q   <= {dy, 1'b0};
			den_q   <= {steps, 1'b0};
			rx_q    <= {1'b0, steps};
			ry_q    <= {1'b0, steps};
			steps_q <= steps;
		end else if (cmd.advance) begin
			px_q <= px_n;
			py_q <= py_n;
			rx_q <= rx_n;
			ry_q <= ry_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.setup) begin
			cnt_q <= '0;
		end else if (cmd.advance) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign sts.last = (cnt_q == steps_q);
	assign pixel_x  = px_q;
	assign pixel_y  = py_q;

endmodule
`default_nettype wire

>>> sv/dda_line_rasterizer_unit.sv
// Top level of the DDA line rasterizer: stream ports, controller and datapath.
// Sequence: a line is taken, set up in the next cycle, and its first
//   pixel is offered on the cycle after that.
// Throughput: one pixel per cycle while the sink is ready; a line of
//   max(|dx|,|dy|) steps yields steps + 1 pixels.
// Reset (arst_n low, asynchronous): the controller returns to idle, ready high.
`default_nettype none
module dda_line_rasterizer_unit
	import dda_pkg::*;
#(
	parameter int COORD_BITS = 6
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// slave side: one line command per transfer
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// s_tdata fields from bit 0 up: start_x, start_y, end_x, end_y, zero pad
	input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]   s_tdata,
	// master side: one pixel per transfer
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// m_tdata fields from bit 0 up: pixel_x, pixel_y, zero pad
	output logic      [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
	// m_tlast: last_pixel, high on the final pixel of the line
	output logic                                     m_tlast
);

	localparam int C     = COORD_BITS;
	localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

	dda_cmd_t      cmd;
	dda_sts_t      sts;
	logic [C-1:0]  pixel_x, pixel_y;

	// The controller sequences idle, setup and emit; it accepts a new line
	// only once every pixel of the previous line has been transferred.
	dda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The datapath keeps the current pixel in registers, which serve as the
	// output register; each step adds twice the delta to a remainder and
	// moves the coordinate by at most one.
	dda_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.start_x (s_tdata[C-1:0]),
		.start_y (s_tdata[2*C-1:C]),
		.end_x   (s_tdata[3*C-1:2*C]),
		.end_y   (s_tdata[4*C-1:3*C]),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y)
	);

	// pack the pixel, zero pad to whole bytes
	assign m_tdata = OUT_W'({pixel_y, pixel_x});
	assign m_tlast = sts.last;

endmodule
`default_nettype wire

>>> sv/dda_checker.sv
// Port-level assertions for the DDA line rasterizer, bound to the top level.
`default_nettype none
module dda_checker #(
	parameter int COORD_BITS = 6
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tvalid,
	input wire logic                              s_tready,
	input wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
	input wire logic                              m_tlast
);

	// hold a stalled pixel
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled pixel changed");

	// never take a line while pixels are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("line accepted while pixels pending");

	// a line transfer is followed by a setup cycle with nothing offered
	a_setup_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid && !s_tready ##1 m_tvalid)
		else $error("setup sequence broken");

	// after the last pixel the block is ready for the next line
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("not idle after last pixel");

endmodule

bind dda_line_rasterizer_unit dda_checker #(.COORD_BITS(COORD_BITS)) u_dda_checker (.*);
`default_nettype wire
